// ===== rtl/pkas_pkg.sv =====
// Shared constants, codes and types of the pair-keyed associative stack.
`timescale 1ns / 1ps
`default_nettype none

package pkas_pkg;

	// Default number of stack entries.
	localparam int PKAS_DEPTH = 64;

	// Field widths of one input word and one result word.
	localparam int OP_W    = 3;
	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;
	localparam int IDX_W   = 6;
	localparam int STAT_W  = 2;
	localparam int IN_W    = 208;
	localparam int OUT_W   = 80;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND  = 3'd2;
	localparam logic [OP_W-1:0] OP_READ  = 3'd3;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// Control that the sequencer broadcasts to every cell of the row.
	typedef struct packed {
		logic start;   // put the search token into the first cell
		logic step;    // move the token one cell along
		logic clear;   // drop the token everywhere
	} scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pkas_cell.sv =====
// One cell of the key row: holds an entry's two key words and a search token.
`timescale 1ns / 1ps
`default_nettype none

module pkas_cell
	import pkas_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_ctl_t        ctl,
	input  wire logic             wr_sel,
	input  wire logic [KEY_W-1:0] wr_key_first,
	input  wire logic [KEY_W-1:0] wr_key_second,
	input  wire logic [KEY_W-1:0] srch_key_first,
	input  wire logic [KEY_W-1:0] srch_key_second,
	input  wire logic             tok_in,
	output logic                  tok_out,
	output logic                  hit
);

	logic [KEY_W-1:0] key_first_q;
	logic [KEY_W-1:0] key_second_q;
	logic             tok_q;

	// Key storage, written when a push lands on this cell.
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			key_first_q  <= wr_key_first;
			key_second_q <= wr_key_second;
		end
	end

	// The token marks the cell being compared this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clear) begin
			tok_q <= 1'b0;
		end else if (ctl.start || ctl.step) begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;
	assign hit     = tok_q && (key_first_q == srch_key_first)
		&& (key_second_q == srch_key_second);

endmodule

`default_nettype wire

// ===== rtl/pkas_chain.sv =====
// Row of key cells; a search token walks it from the bottom entry upward.
`timescale 1ns / 1ps
`default_nettype none

module pkas_chain
	import pkas_pkg::*;
#(
	parameter int DEPTH = PKAS_DEPTH,
	localparam int IW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_ctl_t        ctl,
	input  wire logic             wr_en,
	input  wire logic [IW-1:0]    wr_index,
	input  wire logic [KEY_W-1:0] wr_key_first,
	input  wire logic [KEY_W-1:0] wr_key_second,
	input  wire logic [KEY_W-1:0] srch_key_first,
	input  wire logic [KEY_W-1:0] srch_key_second,
	output logic                  any_hit
);

	logic [DEPTH-1:0] tok;
	logic [DEPTH-1:0] hit;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic tok_prev;
		logic sel;

		// The first cell takes the token from the start strobe.
		if (i == 0) begin : g_head
			assign tok_prev = ctl.start;
		end else begin : g_body
			assign tok_prev = tok[i-1];
		end

		assign sel = wr_en && (wr_index == IW'(i));

		pkas_cell u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.ctl             (ctl),
			.wr_sel          (sel),
			.wr_key_first    (wr_key_first),
			.wr_key_second   (wr_key_second),
			.srch_key_first  (srch_key_first),
			.srch_key_second (srch_key_second),
			.tok_in          (tok_prev),
			.tok_out         (tok[i]),
			.hit             (hit[i])
		);
	end

	// At most one cell holds the token, so this is the compare result.
	assign any_hit = |hit;

endmodule

`default_nettype wire

// ===== rtl/pair_keyed_assoc_stack.sv =====
// Top level of the pair-keyed associative stack: sequencer, value memory, result register.
//
// Channel  Dir  Word contents (lowest bit first)
// s_*      in   operation[2:0] key_first[66:3] key_second[130:67] value_in[194:131]
//              entry_index[200:195], zero pad to 208 bits
// m_*      out  value_out[63:0] found[64] match_index[70:65] status[72:71], pad to 80
//
// Each word goes from decode to the done state and into the output register; pop and
// read values come from a registered read of the value memory. A find first steps the
// token one key cell per cycle until a hit or the top entry. Reset clears the fill
// count and sequencer; stored entries need no clearing. One word is worked on at a
// time; the next is taken while a result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module pair_keyed_assoc_stack
	import pkas_pkg::*;
#(
	parameter int DEPTH = PKAS_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // operation, key_first, key_second, value_in, entry_index
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // value_out, found, match_index, status
);

	localparam int IW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > IDX_W + 1) ? FW : IDX_W + 1;
	localparam int XW = (IW > IDX_W) ? IW : IDX_W;

	// Sequencer states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [FW-1:0]     fill_q;
	logic [IW-1:0]     scan_q;

	logic              res_mem_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_match_q;
	logic [STAT_W-1:0] res_status_q;

	logic              m_valid_q;
	logic [VAL_W-1:0]  m_value_q;
	logic              m_found_q;
	logic [IDX_W-1:0]  m_match_q;
	logic [STAT_W-1:0] m_status_q;

	logic [KEY_W-1:0]  srch_k1_q;
	logic [KEY_W-1:0]  srch_k2_q;
	logic [VAL_W-1:0]  rd_data_q;
	logic [VAL_W-1:0]  mem [DEPTH];

	// Input word fields.
	logic [OP_W-1:0]   in_op;
	logic [KEY_W-1:0]  in_k1;
	logic [KEY_W-1:0]  in_k2;
	logic [VAL_W-1:0]  in_val;
	logic [IDX_W-1:0]  in_idx;

	assign in_op  = s_tdata[2:0];
	assign in_k1  = s_tdata[66:3];
	assign in_k2  = s_tdata[130:67];
	assign in_val = s_tdata[194:131];
	assign in_idx = s_tdata[200:195];

	logic              accept;
	logic              full;
	logic              empty;
	logic              idx_ok;
	logic [FW-1:0]     fill_m1;
	logic [XW-1:0]     idx_x;
	logic [IW-1:0]     idx_ix;
	logic [IW-1:0]     push_ix;
	logic [IW-1:0]     pop_ix;
	logic [XW-1:0]     scan_x;
	logic              scan_last;
	logic              any_hit;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign full      = (fill_q == FW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign idx_ok    = (CW'(in_idx) < CW'(fill_q));
	assign fill_m1   = fill_q - FW'(1);
	assign idx_x     = XW'(in_idx);
	assign idx_ix    = idx_x[IW-1:0];
	assign push_ix   = fill_q[IW-1:0];
	assign pop_ix    = fill_m1[IW-1:0];
	assign scan_x    = XW'(scan_q);
	assign scan_last = (FW'(scan_q) == fill_m1);

	// Decode of an accepted word.
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	logic              mem_re;
	logic [IW-1:0]     mem_ra;
	logic              key_we;
	logic              do_push;
	logic              do_pop;
	logic              do_find;
	logic [STAT_W-1:0] dec_status;

	always_comb begin
		mem_we     = 1'b0;
		mem_wa     = idx_ix;
		mem_re     = 1'b0;
		mem_ra     = idx_ix;
		key_we     = 1'b0;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_find    = 1'b0;
		dec_status = ST_OK;
		unique case (in_op)
			OP_PUSH: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					mem_we  = 1'b1;
					mem_wa  = push_ix;
					key_we  = 1'b1;
					do_push = 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					mem_ra = pop_ix;
					do_pop = 1'b1;
				end
			end
			OP_FIND: begin
				do_find = !empty;
			end
			OP_READ: begin
				if (idx_ok) begin
					mem_re = 1'b1;
				end else begin
					dec_status = ST_RANGE;
				end
			end
			OP_WRITE: begin
				if (idx_ok) begin
					mem_we = 1'b1;
				end else begin
					dec_status = ST_RANGE;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// Token control for the key row.
	scan_ctl_t ctl;

	always_comb begin
		ctl.start = accept && do_find;
		ctl.step  = (state_q == S_SCAN) && !any_hit && !scan_last;
		ctl.clear = (state_q == S_SCAN) && (any_hit || scan_last);
	end

	pkas_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.wr_en           (accept && key_we),
		.wr_index        (push_ix),
		.wr_key_first    (in_k1),
		.wr_key_second   (in_k2),
		.srch_key_first  (srch_k1_q),
		.srch_key_second (srch_k2_q),
		.any_hit         (any_hit)
	);

	// Value memory with a registered read port.
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			mem[mem_wa] <= in_val;
		end
		if (accept && mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Search keys held for the length of a scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			srch_k1_q <= in_k1;
			srch_k2_q <= in_k2;
		end
	end

	// Sequencer, fill count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			scan_q       <= '0;
			res_mem_q    <= 1'b0;
			res_found_q  <= 1'b0;
			res_match_q  <= '0;
			res_status_q <= ST_OK;
			m_valid_q    <= 1'b0;
			m_value_q    <= '0;
			m_found_q    <= 1'b0;
			m_match_q    <= '0;
			m_status_q   <= ST_OK;
		end else begin
			// In the done state the output register is reloaded below instead.
			if (m_valid_q && m_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_mem_q    <= mem_re;
						res_found_q  <= 1'b0;
						res_match_q  <= '0;
						res_status_q <= dec_status;
						scan_q       <= '0;
						if (do_push) begin
							fill_q <= fill_q + FW'(1);
						end else if (do_pop) begin
							fill_q <= fill_m1;
						end
						state_q <= do_find ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (any_hit) begin
						res_found_q <= 1'b1;
						res_match_q <= scan_x[IDX_W-1:0];
						state_q     <= S_DONE;
					end else if (scan_last) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q  <= 1'b1;
						m_value_q  <= res_mem_q ? rd_data_q : '0;
						m_found_q  <= res_found_q;
						m_match_q  <= res_match_q;
						m_status_q <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_W - VAL_W - 1 - IDX_W - STAT_W)'(0),
		m_status_q, m_match_q, m_found_q, m_value_q};

endmodule

`default_nettype wire
